### src/ttbc_pkg.sv
// Shared constants, command codes and helpers for the tap tempo beat clock.
`timescale 1ns / 1ps
package ttbc_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int POSITION_BITS_DEF = 48;

  localparam int CMD_W     = 2;
  localparam int TIME_W    = 32;
  localparam int WEIGHT_W  = 17;
  localparam int POS_OUT_W = 48;
  localparam int BPM_W     = 32;
  localparam int ANTID_W   = 10;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALIGN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BPM_SMOOTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTIDELAY  = 1'b1;

  localparam logic [WEIGHT_W-1:0] ONE_Q16        = 17'd65536;
  localparam logic [WEIGHT_W-1:0] SMOOTH_RESET   = 17'd58982;
  localparam logic [BPM_W-1:0]    BPM_RESET      = 32'd9175040;
  localparam logic [9:0]          BEAT_MB        = 10'd1000;

  // 2^n mod 1000, by doubling with one conditional subtract a step
  function automatic int pow2_mod1000(int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 2;
      if (r >= 1000) r = r - 1000;
    end
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] sat_weight(logic [WEIGHT_W-1:0] w);
    return (w > ONE_Q16) ? ONE_Q16 : w;
  endfunction

endpackage

### src/ttbc_in_if.sv
// Input channel of the beat clock: command, time stamp and tap weight.
`timescale 1ns / 1ps
interface ttbc_in_if import ttbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [TIME_W-1:0]   now_ms;
  logic [WEIGHT_W-1:0] tap_weight;

  modport source(output valid, output cmd, output now_ms, output tap_weight, input ready);
  modport sink(input valid, input cmd, input now_ms, input tap_weight, output ready);
endinterface

### src/ttbc_out_if.sv
// Result channel of the beat clock: position, wrap flag, BPM and ignore flag.
`timescale 1ns / 1ps
interface ttbc_out_if import ttbc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_OUT_W-1:0] position_mb;
  logic                        beat_wrapped;
  logic [BPM_W-1:0]            bpm_display;
  logic                        tap_ignored;

  modport source(output valid, output position_mb, output beat_wrapped,
                 output bpm_display, output tap_ignored, input ready);
  modport sink(input valid, input position_mb, input beat_wrapped,
               input bpm_display, input tap_ignored, output ready);
endinterface

### src/ttbc_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ttbc_divider import ttbc_pkg::*; #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [31:0]   div_r;
  logic [32:0]   trial;
  logic          fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(DW - 1);
          rem_r  <= '0;
          quo_r  <= dividend;
          div_r  <= divisor;
        end
      end else begin
        rem_r <= fits ? 32'(trial - {1'b0, div_r}) : trial[31:0];
        quo_r <= {quo_r[DW-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/tap_tempo_beat_clock_unit.sv
// Top level of the tap tempo beat clock: sequencer, shared multiplier and state.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries a command (query, tap, align), the current time in ms and a
//   Q1.16 tap weight; out_ch returns one result beat for every input beat:
//   position minus anti-delay and a wrap flag on a query, the smoothed BPM
//   always, and an ignore flag on a tap with no elapsed time.
//   cfg_we/cfg_index/cfg_data write bpm_smoothing (index 0) and the anti-delay
//   (index 1); write only while the block is idle.
//   One item is taken at a time; in_ch.ready is high in the idle state only.
//   The result beat becomes valid in the same cycle as in_ch.ready rises again.
//   Align, unused command and ignored tap go straight to the output; a query
//   passes the position product, the fold and the reciprocal product; a tap
//   adds the serial rate divider on DW = max(FRAC_BITS+11, 33) bits (33 at the
//   defaults) and the blend, tempo and smoothing turns of the shared 33x33
//   multiplier. A position with bits set at or above bit 32 takes extra fold
//   steps (at most one at the default width).
//   A finished result waits in the output register; a new item is accepted
//   meanwhile, and its own result is held back until the receiver takes the
//   one before.
//   Reset (rst_n low, synchronous) restores 140 BPM, zero reference time and
//   position, and the default registers.
module tap_tempo_beat_clock_unit import ttbc_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ttbc_in_if.sink              in_ch,
  ttbc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PB  = POSITION_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int DW0 = FB + 11;
  localparam int DW  = (DW0 > 33) ? DW0 : 33;
  localparam int FW  = (PB > 33) ? PB : 33;
  localparam int SH_R = (FB >= 16) ? FB - 16 : 0;
  localparam int SH_L = (FB < 16) ? 16 - FB : 0;
  localparam logic [9:0] P2M    = 10'(pow2_mod1000(PB));
  localparam logic [9:0] FOLD_K = 10'(pow2_mod1000(24));
  // floor(x / 1000) = (x * RECIP_1000) >> 38 for every 32-bit x
  localparam logic signed [32:0] RECIP_1000 = 33'sd274877907;
  localparam logic [31:0] RATE_RESET =
    32'(((64'd140 << FRAC_BITS) + 64'd30) / 64'd60);

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_FOLD, S_R1, S_R2, S_DIV, S_B1, S_B2, S_T1, S_T2,
    S_S1, S_S2, S_OUT
  } state_t;

  state_t              state_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   elapsed_r;
  logic [WEIGHT_W-1:0] w_r;

  logic [WEIGHT_W-1:0] smooth_r;
  logic [ANTID_W-1:0]  antid_r;
  logic [TIME_W-1:0]   ref_time_r;
  logic [PB-1:0]       ref_pos_r;
  logic [31:0]         rate_r;
  logic [BPM_W-1:0]    bpm_r;
  logic [9:0]          lq_mod_r;

  logic [PB-1:0]       cur_r;
  logic [FW-1:0]       fold_r;
  logic [31:0]         target_r;

  logic signed [32:0]  mul_a_r;
  logic signed [32:0]  mul_b_r;
  logic signed [65:0]  prod_r;

  logic                div_start_r;
  logic [DW-1:0]       div_dvd_r;
  logic [31:0]         div_dvs_r;
  logic                div_done;
  logic [DW-1:0]       div_quo;

  logic signed [POS_OUT_W-1:0] wk_pos_r;
  logic                        wk_wrap_r;
  logic                        wk_ign_r;

  logic                        out_valid_r;
  logic signed [POS_OUT_W-1:0] res_pos_r;
  logic                        res_wrap_r;
  logic                        res_ign_r;
  logic [BPM_W-1:0]            res_bpm_r;

  // combinational helpers
  logic [TIME_W-1:0]   elapsed_in;
  logic [PB+65:0]      prod_ext;
  logic [PB-1:0]       cur_nxt;
  logic [FW-1:0]       fold_nxt;
  logic [31:0]         q1000;
  logic [9:0]          u_mod;
  logic [9:0]          c_mod;
  logic [9:0]          m_mod;
  logic [10:0]         e1_raw;
  logic [10:0]         e1;
  logic [10:0]         numv;
  logic [31:0]         new_rate;
  logic [31:0]         rate_nxt;
  logic [63:0]         bpm_t;
  logic [31:0]         target_nxt;
  logic signed [PB-1:0] pos_adj;
  logic                out_load;

  assign elapsed_in = in_ch.now_ms - ref_time_r;
  assign prod_ext   = {{PB{1'b0}}, prod_r};
  assign cur_nxt    = ref_pos_r + prod_ext[FB +: PB];

  // fold the bits above 2^24 down, keeping the value modulo 1000
  assign fold_nxt = FW'(fold_r[FW-1:24]) * FW'(FOLD_K) + FW'(fold_r[23:0]);

  // remainder of the folded value from the reciprocal quotient
  assign q1000 = 32'(prod_r[63:38]) * 32'd1000;
  assign u_mod = 10'(fold_r[31:0] - q1000);

  // floor modulo 1000 of the signed position from the unsigned remainder
  assign c_mod  = cur_r[PB-1] ? P2M : 10'd0;
  assign m_mod  = (u_mod >= c_mod) ? 10'(u_mod - c_mod) : 10'(u_mod + BEAT_MB - c_mod);
  assign e1_raw = {1'b0, m_mod} + 11'd500;
  assign e1     = (e1_raw >= 11'd1000) ? 11'(e1_raw - 11'd1000) : e1_raw;
  assign numv   = 11'd1500 - e1;

  assign new_rate = (div_quo[DW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign rate_nxt = rate_r + prod_r[47:16];

  assign bpm_t      = ({26'd0, prod_r[37:0]} >> SH_R) << SH_L;
  assign target_nxt = (bpm_t[63:32] != '0) ? 32'hFFFF_FFFF : bpm_t[31:0];

  assign pos_adj = $signed(cur_r - PB'(antid_r));

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  ttbc_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (div_dvd_r),
    .divisor   (div_dvs_r),
    .done      (div_done),
    .quotient  (div_quo)
  );

  // sequencer, clock state and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      smooth_r    <= SMOOTH_RESET;
      antid_r     <= '0;
      ref_time_r  <= '0;
      ref_pos_r   <= '0;
      rate_r      <= RATE_RESET;
      bpm_r       <= BPM_RESET;
      lq_mod_r    <= '0;
    end else begin
      div_start_r <= (state_r == S_R2) && (cmd_r != CMD_QUERY);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BPM_SMOOTH: smooth_r <= cfg_data;
          CFG_ANTIDELAY:  antid_r  <= cfg_data[ANTID_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r     <= in_ch.cmd;
            now_r     <= in_ch.now_ms;
            elapsed_r <= elapsed_in;
            w_r       <= sat_weight(in_ch.tap_weight);
            wk_pos_r  <= '0;
            wk_wrap_r <= 1'b0;
            wk_ign_r  <= (in_ch.cmd == CMD_TAP) && (elapsed_in == '0);
            mul_a_r   <= $signed({1'b0, elapsed_in});
            mul_b_r   <= $signed({1'b0, rate_r});
            unique case (in_ch.cmd)
              CMD_QUERY: state_r <= S_P1;
              CMD_TAP: begin
                if (elapsed_in == '0) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_P1;
                end
              end
              CMD_ALIGN: begin
                ref_pos_r <= ref_pos_r + PB'(BEAT_MB);
                state_r   <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_P1: state_r <= S_P2;
        S_P2: begin
          // advance the position and start its reduction modulo one beat
          cur_r   <= cur_nxt;
          fold_r  <= FW'(cur_nxt);
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          // fold until the value fits 32 bits, then take the reciprocal product
          if (fold_r[FW-1:32] != '0) begin
            fold_r <= fold_nxt;
          end else begin
            mul_a_r <= $signed({1'b0, fold_r[31:0]});
            mul_b_r <= RECIP_1000;
            state_r <= S_R1;
          end
        end
        S_R1: state_r <= S_R2;
        S_R2: begin
          if (cmd_r == CMD_QUERY) begin
            wk_wrap_r <= m_mod < lq_mod_r;
            lq_mod_r  <= m_mod;
            wk_pos_r  <= POS_OUT_W'(pos_adj);
            state_r   <= S_OUT;
          end else begin
            div_dvd_r <= DW'(numv) << FB;
            div_dvs_r <= elapsed_r;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mul_a_r <= $signed({1'b0, new_rate}) - $signed({1'b0, rate_r});
            mul_b_r <= $signed({16'd0, w_r});
            state_r <= S_B1;
          end
        end
        S_B1: state_r <= S_B2;
        S_B2: begin
          // blend the rate and re-anchor the reference
          rate_r     <= rate_nxt;
          ref_time_r <= now_r;
          ref_pos_r  <= cur_r;
          mul_a_r    <= $signed({1'b0, rate_nxt});
          mul_b_r    <= 33'sd60;
          state_r    <= S_T1;
        end
        S_T1: state_r <= S_T2;
        S_T2: begin
          target_r <= target_nxt;
          mul_a_r  <= $signed({1'b0, bpm_r}) - $signed({1'b0, target_nxt});
          mul_b_r  <= $signed({16'd0, sat_weight(smooth_r)});
          state_r  <= S_S1;
        end
        S_S1: state_r <= S_S2;
        S_S2: begin
          bpm_r   <= target_r + prod_r[47:16];
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the previous result beat has gone
          if (out_load) begin
            res_pos_r  <= wk_pos_r;
            res_wrap_r <= wk_wrap_r;
            res_ign_r  <= wk_ign_r;
            res_bpm_r  <= bpm_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.position_mb  = res_pos_r;
  assign out_ch.beat_wrapped = res_wrap_r;
  assign out_ch.bpm_display  = res_bpm_r;
  assign out_ch.tap_ignored  = res_ign_r;

endmodule
